>>> design/round_robin_job_task_dispatcher_assert.svh
// Assertion macros shared by the dispatcher's checker.
// Depends on nothing; included by files that assert.
`ifndef ROUND_ROBIN_JOB_TASK_DISPATCHER_ASSERT_SVH
`define ROUND_ROBIN_JOB_TASK_DISPATCHER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define RRJD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dispatcher assertion failed");

// Next-cycle implication, disabled during reset
`define RRJD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dispatcher assertion failed");

`endif

>>> design/rrjd_pkg.sv
// Shared constants for the round-robin job task dispatcher.
// No dependencies; used by the top level and its checker.
package rrjd_pkg;

  // Result status codes (m_tuser)
  localparam logic [2:0] STATUS_SENT    = 3'd0;
  localparam logic [2:0] STATUS_QUEUED  = 3'd1;
  localparam logic [2:0] STATUS_IGNORED = 3'd2;
  localparam logic [2:0] STATUS_FULL    = 3'd3;
  localparam logic [2:0] STATUS_NONE    = 3'd4;

  // Input kinds (s_tuser)
  localparam logic ACTION_NEW_JOB = 1'b0;
  localparam logic ACTION_READY   = 1'b1;

  // One ring entry
  typedef struct packed {
    logic [15:0] job_number;
    logic [15:0] task_count;
  } job_entry_t;

endpackage

>>> design/round_robin_job_task_dispatcher.sv
// Round-robin job task dispatcher: ring of pending jobs in one synchronous RAM.
// Depends on rrjd_pkg.
//
// Usage:
//   Slave channel (s_*): one beat per event. s_tuser is the action (0 new job,
//   1 downstream ready); s_tdata carries job_number and task_total of a new job.
//   Master channel (m_*): exactly one result beat per input beat, in order.
//   m_tuser is the status, m_tdata carries sent_job, tasks_left, jobs_pending.
// Timing:
//   An accepted beat reads the ring head from the RAM in the accept cycle; the
//   next cycle updates the ring and loads the output register, unless the
//   receiver is stalling a previous result. m_tvalid rises with that update.
//   s_tready is low from the accept until the update, so a new beat is taken
//   only after the previous one has updated the ring.
// Stalls:
//   The output register holds a finished beat while a new beat is accepted.
//   If the receiver still stalls when that next item is ready, the item waits
//   in the update step and s_tready stays low until the output frees up.
// Reset:
//   rst (synchronous) empties the ring and drops any pending result. RAM
//   contents are not cleared; only slots written since are ever used.
module round_robin_job_task_dispatcher #(
  parameter int JOB_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] job_number, [31:16] task_total
  input  logic        s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [15:0] sent_job, [31:16] tasks_left,
                                 // [36:32] jobs_pending, [39:37] zero
  output logic [2:0]  m_tuser    // [2:0] status
);

  localparam int SLOT_W = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam int OCC_W  = $clog2(JOB_SLOTS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                 state;
  logic [SLOT_W-1:0]    head_slot;
  logic [SLOT_W-1:0]    tail_slot;
  logic [OCC_W-1:0]     occupancy;

  // Ring storage
  rrjd_pkg::job_entry_t job_ring [JOB_SLOTS];
  rrjd_pkg::job_entry_t rd_entry;

  // Held input beat
  logic                 item_action;
  logic [15:0]          item_number;
  logic [15:0]          item_total;

  logic                 accept;
  logic                 commit;
  logic                 wr_en;
  rrjd_pkg::job_entry_t wr_entry;
  logic [2:0]           status_next;
  logic [15:0]          sent_next;
  logic [15:0]          left_next;
  logic [15:0]          dec_count;
  logic [SLOT_W-1:0]    head_next;
  logic [SLOT_W-1:0]    tail_next;
  logic [OCC_W-1:0]     occupancy_next;
  logic [OCC_W+4:0]     pending_ext;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign commit   = (state == ST_EXEC) && (!m_tvalid || m_tready);
  assign dec_count = rd_entry.task_count - 16'd1;

  function automatic logic [SLOT_W-1:0] advance_slot(input logic [SLOT_W-1:0] slot);
    advance_slot = (slot == SLOT_W'(JOB_SLOTS - 1)) ? '0 : slot + 1'b1;
  endfunction

  // Work out the ring update and the result for the held beat
  always_comb begin
    wr_en          = 1'b0;
    wr_entry       = '{job_number: item_number, task_count: item_total};
    status_next    = rrjd_pkg::STATUS_NONE;
    sent_next      = '0;
    left_next      = '0;
    head_next      = head_slot;
    tail_next      = tail_slot;
    occupancy_next = occupancy;
    if (item_action == rrjd_pkg::ACTION_NEW_JOB) begin
      if (item_total == 16'd0) begin
        status_next = rrjd_pkg::STATUS_IGNORED;
      end else if (occupancy >= OCC_W'(JOB_SLOTS)) begin
        status_next = rrjd_pkg::STATUS_FULL;
      end else begin
        status_next    = rrjd_pkg::STATUS_QUEUED;
        wr_en          = 1'b1;
        tail_next      = advance_slot(tail_slot);
        occupancy_next = occupancy + 1'b1;
      end
    end else begin
      if (occupancy == '0) begin
        status_next = rrjd_pkg::STATUS_NONE;
      end else begin
        status_next = rrjd_pkg::STATUS_SENT;
        sent_next   = rd_entry.job_number;
        left_next   = dec_count;
        head_next   = advance_slot(head_slot);
        if (dec_count == 16'd0) begin
          occupancy_next = occupancy - 1'b1;
        end else begin
          // Move the job to the back of the ring
          wr_en     = 1'b1;
          wr_entry  = '{job_number: rd_entry.job_number, task_count: dec_count};
          tail_next = advance_slot(tail_slot);
        end
      end
    end
  end

  // RAM: read the head every cycle, write the tail on commit
  always_ff @(posedge clk) begin
    rd_entry <= job_ring[head_slot];
    if (commit && wr_en) begin
      job_ring[tail_slot] <= wr_entry;
    end
  end

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      item_action <= s_tuser;
      item_number <= s_tdata[15:0];
      item_total  <= s_tdata[31:16];
    end
  end

  // Control state and ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head_slot <= '0;
      tail_slot <= '0;
      occupancy <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state     <= ST_IDLE;
            head_slot <= head_next;
            tail_slot <= tail_next;
            occupancy <= occupancy_next;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign pending_ext = {5'd0, occupancy_next};

  // Output register: load on commit, hold otherwise
  always_ff @(posedge clk) begin
    if (commit) begin
      m_tuser <= status_next;
      m_tdata <= {3'd0, pending_ext[4:0], left_next, sent_next};
    end
  end

endmodule

>>> design/rrjd_checker.sv
// Port-level checker for the round-robin job task dispatcher, plus its bind.
// Depends on rrjd_pkg and round_robin_job_task_dispatcher_assert.svh.
`include "round_robin_job_task_dispatcher_assert.svh"

module rrjd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [2:0]  m_tuser
);

  logic out_beat;
  logic other_beat;
  logic none_beat;
  assign out_beat   = m_tvalid && m_tready;
  assign other_beat = out_beat && (m_tuser != rrjd_pkg::STATUS_SENT);
  assign none_beat  = out_beat && (m_tuser == rrjd_pkg::STATUS_NONE);

  // Only defined status codes leave the block
  `RRJD_ASSERT_NOW(status_defined, clk, rst, out_beat, (m_tuser <= rrjd_pkg::STATUS_NONE))

  // Job and count fields are zero unless a task was sent
  `RRJD_ASSERT_NOW(idle_fields_zero, clk, rst, other_beat, (m_tdata[31:0] == 32'd0))

  // Nothing to send means the ring is empty
  `RRJD_ASSERT_NOW(none_means_empty, clk, rst, none_beat, (m_tdata[36:32] == 5'd0))

  // A stalled result holds
  `RRJD_ASSERT_NEXT(stall_holds, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind round_robin_job_task_dispatcher rrjd_checker u_rrjd_checker (.*);
